### rtl/core/csi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_pkg
// Shared types, character codes and helpers for the CSI parameter collector.
// ----------------------------------------------------------------------------
package csi_pkg;

  localparam int NUM_ARGS_DEF  = 6;
  localparam int ARG_WIDTH_DEF = 16;

  // Fixed result layout
  localparam int OUT_ARGS      = 6;
  localparam int OUT_ARG_WIDTH = 16;
  localparam int INDEX_WIDTH   = 3;

  localparam logic [7:0] CHAR_AT     = 8'h40; // '@'
  localparam logic [7:0] CHAR_TILDE  = 8'h7E; // '~'
  localparam logic [7:0] CHAR_SEMI   = 8'h3B; // ';'
  localparam logic [7:0] CHAR_QUEST  = 8'h3F; // '?'
  localparam logic [7:0] CHAR_Z_UP   = 8'h5A; // 'Z'
  localparam logic [7:0] CHAR_Z_LOW  = 8'h7A; // 'z'
  localparam logic [7:0] CHAR_ZERO   = 8'h30; // '0'
  localparam logic [7:0] CHAR_NINE   = 8'h39; // '9'
  localparam logic [7:0] CHAR_A_LOW  = 8'h61; // 'a'
  localparam logic [7:0] CHAR_F_LOW  = 8'h66; // 'f'
  localparam logic [7:0] CHAR_A_UP   = 8'h41; // 'A'
  localparam logic [7:0] CHAR_F_UP   = 8'h46; // 'F'
  localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

  typedef enum logic [1:0] {
    STATUS_ABSORBED = 2'd0,
    STATUS_COMPLETE = 2'd1,
    STATUS_REJECTED = 2'd2
  } status_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    logic [7:0] v;
    r = '{ok: 1'b0, value: 4'd0};
    v = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
      r.ok = 1'b1;
    end else if (c >= CHAR_A_LOW && c <= CHAR_F_LOW) begin
      v = c - CHAR_A_LOW + HEX_LETTER_BASE;
      r.ok = 1'b1;
    end else if (c >= CHAR_A_UP && c <= CHAR_F_UP) begin
      v = c - CHAR_A_UP + HEX_LETTER_BASE;
      r.ok = 1'b1;
    end
    r.value = v[3:0];
    return r;
  endfunction

endpackage

### rtl/core/csi_parameter_collector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_parameter_collector_core
// Collects numeric parameters of a CSI control sequence, one byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_byte) takes the bytes that follow
//   ESC [. Every request yields exactly one result on the output channel
//   (out_valid/out_ready): a status, the final byte on completion, the
//   parameter values, the ';' count and the private flag.
//   out_valid rises once the request has moved from the input register
//   into the result register; a new byte is taken every cycle unless
//   the output stalls. The parameter update (shift-add times ten or a
//   4-bit hex shift) sits between the input register and the result
//   register, so one request completes per cycle unless the output stalls.
//   When out_ready is low the result register holds; the input register
//   still fills, and in_ready drops only when both stages hold a request.
//   Synchronous reset clears the parameters, index and flags and empties
//   both stages; the block takes bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
module csi_parameter_collector_core #(
  parameter int NUM_ARGS  = csi_pkg::NUM_ARGS_DEF,
  parameter int ARG_WIDTH = csi_pkg::ARG_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          status,
  output logic [7:0]                          final_char,
  output logic [csi_pkg::OUT_ARG_WIDTH-1:0]   arg0,
  output logic [csi_pkg::OUT_ARG_WIDTH-1:0]   arg1,
  output logic [csi_pkg::OUT_ARG_WIDTH-1:0]   arg2,
  output logic [csi_pkg::OUT_ARG_WIDTH-1:0]   arg3,
  output logic [csi_pkg::OUT_ARG_WIDTH-1:0]   arg4,
  output logic [csi_pkg::OUT_ARG_WIDTH-1:0]   arg5,
  output logic [csi_pkg::INDEX_WIDTH-1:0]     arg_index,
  output logic                                private_flag
);

  localparam int PTR_W = $clog2(NUM_ARGS + 1);

  // Input stage
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Collector state
  logic [ARG_WIDTH-1:0] arg_store [NUM_ARGS];
  logic [PTR_W-1:0]     arg_ptr;
  logic                 question_seen;
  logic                 hex_mode;
  logic                 digit_seen;

  // Update logic
  logic [ARG_WIDTH-1:0] arg_upd [NUM_ARGS];
  logic [PTR_W-1:0]     ptr_upd;
  logic                 question_upd;
  logic                 hex_upd;
  logic                 digit_upd;
  logic                 dig_hex;
  logic                 dig_dec;
  logic                 clear_all;
  logic                 prefix_ok;
  csi_pkg::hex_digit_t  hd;
  csi_pkg::status_t     status_next;
  logic [7:0]           final_next;
  logic [csi_pkg::OUT_ARG_WIDTH-1:0] arg_out_next [csi_pkg::OUT_ARGS];
  logic [3:0]           ptr_ext;

  // Result register
  csi_pkg::status_t     status_q;
  logic [csi_pkg::OUT_ARG_WIDTH-1:0] arg_q [csi_pkg::OUT_ARGS];

  logic out_free;
  logic fire;

  assign out_free = !out_valid || out_ready;
  assign fire     = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_comb begin
    hd           = csi_pkg::hex_decode(s1_byte);
    prefix_ok    = (arg_ptr == '0) && !digit_seen;
    ptr_upd      = arg_ptr;
    question_upd = question_seen;
    hex_upd      = hex_mode;
    digit_upd    = digit_seen;
    dig_hex      = 1'b0;
    dig_dec      = 1'b0;
    clear_all    = 1'b0;
    status_next  = csi_pkg::STATUS_ABSORBED;
    final_next   = 8'd0;
    if (s1_byte == csi_pkg::CHAR_Z_UP && prefix_ok) begin
      // leading 'Z' is swallowed
    end else if (s1_byte == csi_pkg::CHAR_Z_LOW && prefix_ok) begin
      hex_upd = 1'b1;
    end else if (hex_mode && hd.ok) begin
      digit_upd = 1'b1;
      dig_hex   = 1'b1;
    end else if (s1_byte >= csi_pkg::CHAR_ZERO && s1_byte <= csi_pkg::CHAR_NINE) begin
      digit_upd = 1'b1;
      dig_dec   = 1'b1;
    end else if (s1_byte == csi_pkg::CHAR_SEMI) begin
      if (arg_ptr < PTR_W'(NUM_ARGS)) begin
        ptr_upd = arg_ptr + 1'b1;
      end
    end else if (s1_byte == csi_pkg::CHAR_QUEST) begin
      question_upd = 1'b1;
    end else if (s1_byte >= csi_pkg::CHAR_AT && s1_byte < csi_pkg::CHAR_TILDE) begin
      status_next = csi_pkg::STATUS_COMPLETE;
      final_next  = s1_byte;
      clear_all   = 1'b1;
    end else begin
      status_next = csi_pkg::STATUS_REJECTED;
    end
  end

  // One lane per parameter; only the lane at arg_ptr takes the digit.
  for (genvar i = 0; i < NUM_ARGS; i++) begin : g_lane
    logic sel;
    assign sel = (arg_ptr == PTR_W'(i));
    always_comb begin
      arg_upd[i] = arg_store[i];
      if (sel && dig_hex) begin
        arg_upd[i] = (arg_store[i] << 4) | ARG_WIDTH'(hd.value);
      end else if (sel && dig_dec) begin
        arg_upd[i] = (arg_store[i] << 3) + (arg_store[i] << 1) + ARG_WIDTH'(hd.value);
      end
    end
  end

  for (genvar i = 0; i < csi_pkg::OUT_ARGS; i++) begin : g_out
    if (i < NUM_ARGS) begin : g_used
      logic [31:0] ext;
      assign ext             = 32'(arg_upd[i]);
      assign arg_out_next[i] = ext[csi_pkg::OUT_ARG_WIDTH-1:0];
    end else begin : g_unused
      assign arg_out_next[i] = '0;
    end
  end

  assign ptr_ext = 4'(ptr_upd);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ARGS; i++) begin
        arg_store[i] <= '0;
      end
      arg_ptr       <= '0;
      question_seen <= 1'b0;
      hex_mode      <= 1'b0;
      digit_seen    <= 1'b0;
    end else if (fire) begin
      for (int i = 0; i < NUM_ARGS; i++) begin
        arg_store[i] <= clear_all ? '0 : arg_upd[i];
      end
      arg_ptr       <= clear_all ? '0 : ptr_upd;
      question_seen <= !clear_all && question_upd;
      hex_mode      <= !clear_all && hex_upd;
      digit_seen    <= !clear_all && digit_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
    if (fire) begin
      status_q     <= status_next;
      final_char   <= final_next;
      arg_q        <= arg_out_next;
      arg_index    <= ptr_ext[csi_pkg::INDEX_WIDTH-1:0];
      private_flag <= question_upd;
    end
  end

  assign status = status_q;
  assign arg0   = arg_q[0];
  assign arg1   = arg_q[1];
  assign arg2   = arg_q[2];
  assign arg3   = arg_q[3];
  assign arg4   = arg_q[4];
  assign arg5   = arg_q[5];

endmodule
